// ----- hw/rtl/cmio_pkg.sv -----
// Package for the console memory and I/O decoder.
// Command, result-source, I/O port and register codes, field widths, decode constants.
// No dependencies.
package cmio_pkg;

    localparam int RAM_BYTES = 8192;              // power of two, 1024 to 65536
    localparam int RAM_AW    = $clog2(RAM_BYTES);

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;

    typedef enum logic [1:0] {
        CMD_MEM_RD = 2'd0,
        CMD_MEM_WR = 2'd1,
        CMD_IO_RD  = 2'd2,
        CMD_IO_WR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        SRC_LOCAL = 2'd0,
        SRC_ROM   = 2'd1,
        SRC_SOUND = 2'd2,
        SRC_VIDEO = 2'd3
    } src_t;

    localparam logic [2:0] PORT_MEM_CTL  = 3'd0;
    localparam logic [2:0] PORT_IO_CTL   = 3'd1;
    localparam logic [2:0] PORT_VCOUNT   = 3'd2;
    localparam logic [2:0] PORT_HLATCH   = 3'd3;
    localparam logic [2:0] PORT_VID_DATA = 3'd4;
    localparam logic [2:0] PORT_VID_CTL  = 3'd5;
    localparam logic [2:0] PORT_PAD_A    = 3'd6;
    localparam logic [2:0] PORT_PAD_B    = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANKED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LINE  = 2'd2;

    localparam logic [15:0] RAM_BASE      = 16'hC000;
    localparam logic [15:0] MAPPER_BASE   = 16'hFFFC;
    localparam logic [15:0] ROM_FIXED_END = 16'h0400;

    localparam int MC_RAM_OFF_BIT = 4;
    localparam int MC_PAD_OFF_BIT = 2;
    localparam logic [7:0] TH_MASK = 8'hAA;

    // line timing, in master clocks
    localparam int LINE_CLOCKS = 684;
    localparam int H_OFFSET    = 94 - 3;
    localparam int V_OFFSET    = (94 - 16 * 2) - 18;

    // shared divider: 64-bit dividend, divisor below 1024
    localparam int DIV_DVD_W   = 64;
    localparam int DIV_DSR_W   = 10;
    localparam int DIV_BITS    = 4;
    localparam int DIV_STEPS   = DIV_DVD_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef struct packed {
        logic        video_port;
        logic [21:0] rom_address;
        src_t        source;
        logic [7:0]  read_data;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// ----- hw/rtl/console_memory_and_io_decoder_core.sv -----
// Console memory and I/O decoder, top level.
// Work RAM, page and control registers, shared divider for the H and V counters.
// Depends on cmio_pkg.
//
// Decodes one CPU bus transaction per clock unless a divide or a stalled output holds it off:
// memory reads return work RAM data or a ROM byte address, banked or not, memory writes update
// work RAM and the page registers, I/O accesses reach the control bytes, pads, counters, or
// are forwarded to the sound or video chip. Results leave in input order, through the stage-1
// register and then the output register. A V-counter read and an I/O-control write that raises
// TH hold off the next input until the divider is done: both run the 64-bit timestamp through
// one shared radix-16 restoring divider, once by 684 and, for the V counter, once more by
// lines_per_frame. After reset the 8192-byte work RAM is swept to zero, one byte a cycle;
// s_tready stays low meanwhile, configuration writes are taken as always.
module console_memory_and_io_decoder_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [cmio_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cmio_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // command[1:0], address[17:2], write_data[25:18], timestamp[89:26],
    // pad_a[97:90], pad_b[105:98]
    input  logic [cmio_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // read_data[7:0], source[9:8], rom_address[31:10], video_port[32]
    output logic [cmio_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import cmio_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_READY,
        ST_DIV_LINE,
        ST_DIV_FRAME,
        ST_EMIT
    } state_t;

    localparam int OUT_PAD = OUT_TDATA_W - RESULT_W;

    state_t                 state_reg;
    logic [RAM_AW-1:0]      clr_cnt_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic                   div_vcnt_reg;

    logic                   rom_banked_reg;
    logic [9:0]             lines_reg;
    logic [8:0]             first_line_reg;
    logic [7:0]             mem_ctl_reg;
    logic [7:0]             io_ctl_reg;
    logic [7:0]             h_latch_reg;
    logic [7:0]             page_reg [4];

    logic [7:0]             ram_mem [RAM_BYTES];
    logic [7:0]             ram_q_reg;

    logic                   p1_valid_reg;
    result_t                p1_res_reg;
    logic                   p1_use_ram_reg;
    logic                   m_tvalid_reg;
    result_t                out_res_reg;

    logic [DIV_DVD_W-1:0]   dvd_reg;
    logic [DIV_DSR_W-1:0]   rem_reg;
    logic [DIV_DSR_W-1:0]   dsr_reg;
    logic [7:0]             vres_reg;
    logic [DIV_DVD_W-1:0]   dvd_next;
    logic [DIV_DSR_W-1:0]   rem_next;

    cmd_t                   cmd;
    logic [15:0]            addr;
    logic [7:0]             wdata;
    logic [63:0]            ts;
    logic [7:0]             pad_a;
    logic [7:0]             pad_b;
    logic [2:0]             io_port;

    logic                   accept;
    logic                   p1_go;
    logic                   out_free;
    result_t                res;
    logic                   use_ram;
    logic                   ram_wr_item;
    logic                   page_we;
    logic [1:0]             page_idx;
    logic                   mem_ctl_we;
    logic                   io_ctl_we;
    logic                   start_v;
    logic                   start_h;

    logic                   ram_we;
    logic [RAM_AW-1:0]      ram_addr;
    logic [7:0]             ram_wdata;

    logic [19:0]            vprod;
    logic [20:0]            vofs;
    logic [11:0]            hdiff;
    logic [DIV_DSR_W-1:0]   vrem;
    logic [7:0]             vval;
    logic                   div_last;

    assign cmd     = cmd_t'(s_tdata[1:0]);
    assign addr    = s_tdata[17:2];
    assign wdata   = s_tdata[25:18];
    assign ts      = s_tdata[89:26];
    assign pad_a   = s_tdata[97:90];
    assign pad_b   = s_tdata[105:98];
    assign io_port = {addr[7:6], addr[0]};

    assign out_free = !m_tvalid_reg || m_tready;
    assign p1_go    = !p1_valid_reg || out_free;
    assign s_tready = (state_reg == ST_READY) && p1_go;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, out_res_reg};

    // transaction decode
    always_comb begin
        res         = '0;
        use_ram     = 1'b0;
        ram_wr_item = 1'b0;
        page_we     = 1'b0;
        page_idx    = 2'd2;
        mem_ctl_we  = 1'b0;
        io_ctl_we   = 1'b0;
        start_v     = 1'b0;
        start_h     = 1'b0;
        case (cmd)
            CMD_MEM_RD: begin
                if (addr >= RAM_BASE) begin
                    if (mem_ctl_reg[MC_RAM_OFF_BIT]) begin
                        res.read_data = 8'hFF;
                    end else begin
                        use_ram = 1'b1;
                    end
                end else if (addr < ROM_FIXED_END || !rom_banked_reg) begin
                    res.source      = SRC_ROM;
                    res.rom_address = {6'd0, addr};
                end else begin
                    res.source      = SRC_ROM;
                    res.rom_address = {page_reg[addr[15:14]], addr[13:0]};
                end
            end
            CMD_MEM_WR: begin
                if (!mem_ctl_reg[MC_RAM_OFF_BIT]) begin
                    ram_wr_item = (addr >= RAM_BASE);
                    if (rom_banked_reg) begin
                        if (addr >= MAPPER_BASE) begin
                            page_we  = 1'b1;
                            page_idx = addr[1:0] - 2'd1;
                        end else if (addr[15:14] == 2'd2) begin
                            page_we  = 1'b1;
                        end
                    end
                end
            end
            CMD_IO_RD: begin
                case (io_port)
                    PORT_MEM_CTL, PORT_IO_CTL: res.read_data = 8'hFF;
                    PORT_VCOUNT:   start_v = 1'b1;
                    PORT_HLATCH:   res.read_data = h_latch_reg;
                    PORT_VID_DATA: res.source = SRC_VIDEO;
                    PORT_VID_CTL: begin
                        res.source     = SRC_VIDEO;
                        res.video_port = 1'b1;
                    end
                    PORT_PAD_A: res.read_data = mem_ctl_reg[MC_PAD_OFF_BIT] ? 8'hFF : pad_a;
                    PORT_PAD_B: res.read_data = mem_ctl_reg[MC_PAD_OFF_BIT] ? 8'hFF : pad_b;
                    default: res.read_data = 8'hFF;
                endcase
            end
            CMD_IO_WR: begin
                case (io_port)
                    PORT_MEM_CTL: mem_ctl_we = 1'b1;
                    PORT_IO_CTL: begin
                        io_ctl_we = 1'b1;
                        start_h   = ((io_ctl_reg & TH_MASK) == 8'd0) &&
                                    ((wdata & TH_MASK) != 8'd0);
                    end
                    PORT_VCOUNT, PORT_HLATCH: res.source = SRC_SOUND;
                    PORT_VID_DATA: res.source = SRC_VIDEO;
                    PORT_VID_CTL: begin
                        res.source     = SRC_VIDEO;
                        res.video_port = 1'b1;
                    end
                    default: res = '0;
                endcase
            end
            default: res = '0;
        endcase
    end

    // work RAM port: clearing sweep or transaction access
    assign ram_we    = (state_reg == ST_CLEAR) || (accept && ram_wr_item);
    assign ram_addr  = (state_reg == ST_CLEAR) ? clr_cnt_reg : addr[RAM_AW-1:0];
    assign ram_wdata = (state_reg == ST_CLEAR) ? 8'd0 : wdata;

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            ram_mem[ram_addr] <= ram_wdata;
        end
        if (accept && use_ram) begin
            ram_q_reg <= ram_mem[ram_addr];
        end
    end

    // divider step: DIV_BITS quotient bits per cycle
    always_comb begin
        logic [DIV_DSR_W:0] trial;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial    = {rem_next, dvd_next[DIV_DVD_W-1]};
            dvd_next = {dvd_next[DIV_DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next    = DIV_DSR_W'(trial - {1'b0, dsr_reg});
                dvd_next[0] = 1'b1;
            end else begin
                rem_next = trial[DIV_DSR_W-1:0];
            end
        end
    end

    assign vprod    = 20'(lines_reg) * 20'(LINE_CLOCKS);
    assign vofs     = {1'b0, vprod} - 21'(V_OFFSET);
    assign hdiff    = {2'd0, rem_next} - 12'(H_OFFSET);
    assign vrem     = (lines_reg == 10'd0) ? '0 : rem_next;
    assign vval     = vrem[7:0] - first_line_reg[7:0];
    assign div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READY && accept) begin
            dvd_reg <= start_v ? (ts + {{43{vofs[20]}}, vofs}) : ts;
            rem_reg <= '0;
            dsr_reg <= DIV_DSR_W'(LINE_CLOCKS);
        end else if (state_reg == ST_DIV_LINE && div_last) begin
            dvd_reg <= dvd_next;
            rem_reg <= '0;
            dsr_reg <= lines_reg;
        end else if (state_reg == ST_DIV_LINE || state_reg == ST_DIV_FRAME) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
        if (state_reg == ST_DIV_FRAME && div_last) begin
            vres_reg <= vval;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            div_cnt_reg  <= '0;
            div_vcnt_reg <= 1'b0;
            h_latch_reg  <= 8'd0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == '1) begin
                        state_reg <= ST_READY;
                    end
                end
                ST_READY: begin
                    div_cnt_reg <= '0;
                    if (accept && (start_v || start_h)) begin
                        div_vcnt_reg <= start_v;
                        state_reg    <= ST_DIV_LINE;
                    end
                end
                ST_DIV_LINE: begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_last) begin
                        if (div_vcnt_reg) begin
                            state_reg <= ST_DIV_FRAME;
                        end else begin
                            h_latch_reg <= hdiff[9:2];
                            state_reg   <= ST_READY;
                        end
                    end
                end
                ST_DIV_FRAME: begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_last) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (p1_go) begin
                        state_reg <= ST_READY;
                    end
                end
                default: state_reg <= ST_CLEAR;
            endcase
        end
    end

    // configuration and architectural registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_banked_reg <= 1'b1;
            lines_reg      <= 10'd262;
            first_line_reg <= 9'd0;
            mem_ctl_reg    <= 8'd0;
            io_ctl_reg     <= 8'd0;
            for (int i = 0; i < 4; i++) begin
                page_reg[i] <= 8'd0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ROM_BANKED: rom_banked_reg <= cfg_wr_data[0];
                    CFG_LINES:      lines_reg      <= cfg_wr_data;
                    CFG_FIRST_LINE: first_line_reg <= cfg_wr_data[8:0];
                    default: ;
                endcase
            end
            if (accept && mem_ctl_we) begin
                mem_ctl_reg <= wdata;
            end
            if (accept && io_ctl_we) begin
                io_ctl_reg <= wdata;
            end
            if (accept && page_we) begin
                page_reg[page_idx] <= wdata;
            end
        end
    end

    // result pipeline: stage 1 waits for RAM data, then the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (p1_go) begin
                p1_valid_reg <= (accept && !start_v) || (state_reg == ST_EMIT);
            end
            if (out_free) begin
                m_tvalid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_go) begin
            if (state_reg == ST_EMIT) begin
                p1_res_reg           <= '0;
                p1_res_reg.read_data <= vres_reg;
                p1_use_ram_reg       <= 1'b0;
            end else begin
                p1_res_reg     <= res;
                p1_use_ram_reg <= use_ram;
            end
        end
        if (out_free && p1_valid_reg) begin
            out_res_reg <= p1_res_reg;
            if (p1_use_ram_reg) begin
                out_res_reg.read_data <= ram_q_reg;
            end
        end
    end

endmodule

// ----- hw/rtl/cmio_checker.sv -----
// Port-level checks for the console memory and I/O decoder.
// Bound to console_memory_and_io_decoder_core; depends on cmio_pkg.
module cmio_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [cmio_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import cmio_pkg::*;

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("input ready or result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transaction changed");

    a_rom_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[9:8] != SRC_ROM) |-> m_tdata[31:10] == 22'd0)
        else $error("ROM address on a non-ROM result");

    a_data_local: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[9:8] != SRC_LOCAL) |-> m_tdata[7:0] == 8'd0)
        else $error("read data on a forwarded result");

    a_video_port: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[9:8] == SRC_VIDEO)
        else $error("video port flag on a non-video result");

endmodule

bind console_memory_and_io_decoder_core cmio_checker u_cmio_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/tb_console_memory_and_io_decoder_core.sv -----
`timescale 1ns / 1ps
// Self-checking bench for console_memory_and_io_decoder_core: directed and random bus
// transactions with a bit-accurate predictor of RAM, mapper, I/O ports and counters.
// Depends on cmio_pkg and the core RTL.
module tb_console_memory_and_io_decoder_core;
    import cmio_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int MAX_REPORTS = 40;

    typedef struct {
        cmd_t        command;
        logic [15:0] address;
        logic [7:0]  wdata;
        logic [63:0] stamp;
        logic [7:0]  pad_a;
        logic [7:0]  pad_b;
    } access_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // predictor state
    logic [7:0] mirror_ram [RAM_BYTES];
    logic [7:0] mirror_pages [4];
    logic [7:0] mirror_mem_ctl;
    logic [7:0] mirror_io_ctl;
    logic [7:0] mirror_h_latch;
    logic       cfg_rom_banked;
    logic [9:0] cfg_lines;
    logic [8:0] cfg_first_line;

    result_t pending_results[$];
    int      mismatches = 0;
    int      idle_pct = 33;

    console_memory_and_io_decoder_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] horizontal_count(input logic [63:0] stamp);
        logic [31:0] h;
        h = 32'(stamp % 64'd684);
        h = h - 32'd94 + 32'd3;
        h = h >> 2;
        return h[7:0];
    endfunction

    function automatic logic [7:0] vertical_count(input logic [63:0] stamp);
        logic [63:0] n;
        logic [63:0] v;
        n = 64'(cfg_lines);
        v = stamp + 64'd18 - 64'd62 + 64'd684 * n;
        v = v / 64'd684;
        v = (n != 0) ? v % n : 64'd0;
        v = v - 64'(cfg_first_line);
        return v[7:0];
    endfunction

    // updates the predictor state and returns the result of one transaction
    function automatic result_t decode_access(input access_t a);
        result_t          r;
        logic [2:0]       port;
        logic [RAM_AW-1:0] ra;
        r = '0;
        port = {a.address[7:6], a.address[0]};
        ra = a.address[RAM_AW-1:0];
        case (a.command)
            CMD_MEM_RD: begin
                if (a.address >= RAM_BASE) begin
                    r.read_data = mirror_mem_ctl[MC_RAM_OFF_BIT] ? 8'hFF : mirror_ram[ra];
                end else if (a.address < ROM_FIXED_END || !cfg_rom_banked) begin
                    r.source = SRC_ROM;
                    r.rom_address = 22'(a.address);
                end else begin
                    r.source = SRC_ROM;
                    r.rom_address = {mirror_pages[a.address[15:14]], a.address[13:0]};
                end
            end
            CMD_MEM_WR: begin
                if (!mirror_mem_ctl[MC_RAM_OFF_BIT]) begin
                    if (a.address >= RAM_BASE) mirror_ram[ra] = a.wdata;
                    if (cfg_rom_banked) begin
                        if (a.address >= MAPPER_BASE) begin
                            mirror_pages[2'(a.address - 16'd1)] = a.wdata;
                        end else if (a.address[15:14] == 2'b10) begin
                            mirror_pages[2] = a.wdata;
                        end
                    end
                end
            end
            CMD_IO_RD: begin
                case (port)
                    PORT_MEM_CTL, PORT_IO_CTL: r.read_data = 8'hFF;
                    PORT_VCOUNT:   r.read_data = vertical_count(a.stamp);
                    PORT_HLATCH:   r.read_data = mirror_h_latch;
                    PORT_VID_DATA: r.source = SRC_VIDEO;
                    PORT_VID_CTL: begin
                        r.source = SRC_VIDEO;
                        r.video_port = 1'b1;
                    end
                    PORT_PAD_A: r.read_data = mirror_mem_ctl[MC_PAD_OFF_BIT] ? 8'hFF : a.pad_a;
                    default:    r.read_data = mirror_mem_ctl[MC_PAD_OFF_BIT] ? 8'hFF : a.pad_b;
                endcase
            end
            default: begin
                case (port)
                    PORT_MEM_CTL: mirror_mem_ctl = a.wdata;
                    PORT_IO_CTL: begin
                        // TH rising edge latches the H count
                        if ((mirror_io_ctl & TH_MASK) == 0 && (a.wdata & TH_MASK) != 0) begin
                            mirror_h_latch = horizontal_count(a.stamp);
                        end
                        mirror_io_ctl = a.wdata;
                    end
                    PORT_VCOUNT, PORT_HLATCH: r.source = SRC_SOUND;
                    PORT_VID_DATA: r.source = SRC_VIDEO;
                    PORT_VID_CTL: begin
                        r.source = SRC_VIDEO;
                        r.video_port = 1'b1;
                    end
                    default: ;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [15:0] port_address(input logic [2:0] p);
        return {8'($urandom), p[2:1], 5'($urandom), p[0]};
    endfunction

    function automatic access_t mk_access(input cmd_t c, input logic [15:0] addr,
                                          input logic [7:0] wd, input logic [63:0] stamp);
        access_t a;
        a.command = c;
        a.address = addr;
        a.wdata   = wd;
        a.stamp   = stamp;
        a.pad_a   = 8'($urandom);
        a.pad_b   = 8'($urandom);
        return a;
    endfunction

    function automatic access_t random_access();
        access_t    a;
        int         pick;
        logic [2:0] port;
        a = mk_access(cmd_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                      {$urandom, $urandom});
        if ($urandom_range(0, 1)) a.stamp = 64'($urandom_range(0, 4000));
        pick = $urandom_range(0, 99);
        if (!a.command[1]) begin
            if (pick < 35)      a.address = {2'b11, 14'($urandom)};
            else if (pick < 45) a.address = {14'h3FFF, 2'($urandom)};
            else if (pick < 60) a.address = {2'b10, 14'($urandom)};
            else if (pick < 70) a.address = {6'd0, 10'($urandom)};
        end else begin
            port = 3'($urandom);
            a.address = port_address(port);
            if (a.command == CMD_IO_WR) begin
                // keep RAM mostly on, and drop TH often so rising edges happen
                if (port == PORT_MEM_CTL && pick < 85) a.wdata[MC_RAM_OFF_BIT] = 1'b0;
                if (port == PORT_IO_CTL && pick < 45) a.wdata = a.wdata & ~TH_MASK;
            end
        end
        return a;
    endfunction

    task automatic send_access(input access_t a);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[105:0] = {a.pad_b, a.pad_a, a.stamp, a.wdata, a.address, a.command};
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(decode_access(a));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic rb, input logic [9:0] lines,
                                  input logic [8:0] first);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_ROM_BANKED;
        cfg_wr_data <= CFG_DATA_W'(rb);
        @(posedge aclk);
        cfg_index   <= CFG_LINES;
        cfg_wr_data <= CFG_DATA_W'(lines);
        @(posedge aclk);
        cfg_index   <= CFG_FIRST_LINE;
        cfg_wr_data <= CFG_DATA_W'(first);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_rom_banked = rb;
        cfg_lines      = lines;
        cfg_first_line = first;
    endtask

    task automatic test_memory_map();
        send_access(mk_access(CMD_MEM_WR, 16'hC000, 8'h5A, 64'd0));
        send_access(mk_access(CMD_MEM_RD, 16'hE000, 8'h00, 64'd0));   // RAM mirror
        send_access(mk_access(CMD_MEM_WR, 16'hFFFF, 8'h81, 64'd0));
        send_access(mk_access(CMD_MEM_WR, 16'hFFFD, 8'h03, 64'd0));
        send_access(mk_access(CMD_MEM_WR, 16'hFFFC, 8'hFF, 64'd0));
        send_access(mk_access(CMD_MEM_WR, 16'hA5A5, 8'h7E, 64'd0));   // alternative mapper
        send_access(mk_access(CMD_MEM_RD, 16'h03FF, 8'h00, 64'd0));   // unbanked first 1 KiB
        send_access(mk_access(CMD_MEM_RD, 16'h0400, 8'h00, 64'd0));
        send_access(mk_access(CMD_MEM_RD, 16'hBFFF, 8'h00, 64'd0));
        send_access(mk_access(CMD_MEM_RD, 16'hFFFC, 8'h00, 64'd0));
        send_access(mk_access(CMD_IO_WR, port_address(PORT_MEM_CTL), 8'h10, 64'd0));
        send_access(mk_access(CMD_MEM_WR, 16'hC000, 8'h33, 64'd0));   // RAM off: dropped
        send_access(mk_access(CMD_MEM_RD, 16'hC000, 8'h00, 64'd0));
        apply_settings(1'b0, 10'd262, 9'd0);
        send_access(mk_access(CMD_MEM_RD, 16'h8123, 8'h00, 64'd0));
        apply_settings(1'b1, 10'd262, 9'd0);
    endtask

    task automatic test_io_ports();
        for (int p = 0; p < 8; p++) begin
            send_access(mk_access(CMD_IO_RD, port_address(3'(p)), 8'h00, '1));
        end
        send_access(mk_access(CMD_IO_RD, port_address(PORT_VCOUNT), 8'h00, 64'd0));
        send_access(mk_access(CMD_IO_WR, port_address(PORT_IO_CTL), 8'h02, 64'd50));
        send_access(mk_access(CMD_IO_RD, port_address(PORT_HLATCH), 8'h00, 64'd0));
        send_access(mk_access(CMD_IO_WR, port_address(PORT_IO_CTL), 8'h80, 64'd683));
        send_access(mk_access(CMD_IO_WR, port_address(PORT_MEM_CTL), 8'h04, 64'd0));
        send_access(mk_access(CMD_IO_RD, port_address(PORT_PAD_B), 8'h00, 64'd0));
        send_access(mk_access(CMD_IO_WR, port_address(PORT_HLATCH), 8'hFF, 64'd0));
        send_access(mk_access(CMD_IO_WR, port_address(PORT_VID_CTL), 8'h00, 64'd0));
        send_access(mk_access(CMD_IO_WR, port_address(PORT_PAD_A), 8'hFF, 64'd0));
    endtask

    task automatic test_random_traffic();
        logic       rb;
        logic [9:0] lines;
        logic [8:0] first;
        int         count;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin rb = 1'b1; lines = 10'd262; first = 9'd0;   count = 400; end
                1: begin rb = 1'b0; lines = 10'd1;   first = 9'd511; count = 200; end
                2: begin rb = 1'b1; lines = 10'd512; first = 9'd255; count = 300; end
                3: begin rb = 1'b1; lines = 10'd313; first = 9'd16;  count = 300; end
                default: begin
                    rb    = 1'($urandom_range(0, 1));
                    lines = 10'($urandom_range(1, 512));
                    first = 9'($urandom_range(0, 511));
                    count = 200;
                end
            endcase
            apply_settings(rb, lines, first);
            idle_pct = (ph == 2) ? 0 : 33;
            repeat (count) send_access(random_access());
        end
        idle_pct = 33;
    endtask

    task automatic report_mismatch(input string what, input logic [39:0] want,
                                   input logic [39:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge aclk) begin : check_result
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[RESULT_W-1:0]);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", '0, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", want.read_data, got.read_data);
                if (got.source !== want.source)
                    report_mismatch("source", want.source, got.source);
                if (got.rom_address !== want.rom_address)
                    report_mismatch("rom_address", want.rom_address, got.rom_address);
                if (got.video_port !== want.video_port)
                    report_mismatch("video_port", want.video_port, got.video_port);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= CFG_ROM_BANKED;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        m_tready    <= 1'b0;
        foreach (mirror_ram[i]) mirror_ram[i] = 8'h00;
        foreach (mirror_pages[i]) mirror_pages[i] = 8'h00;
        mirror_mem_ctl = 8'h00;
        mirror_io_ctl  = 8'h00;
        mirror_h_latch = 8'h00;
        cfg_rom_banked = 1'b1;
        cfg_lines      = 10'd262;
        cfg_first_line = 9'd0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_memory_map();
        test_io_ports();
        test_random_traffic();

        wait_idle();
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/cmio_pkg.sv
hw/rtl/console_memory_and_io_decoder_core.sv
hw/rtl/cmio_checker.sv
bench/tb_console_memory_and_io_decoder_core.sv
